/* design/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Types, widths and helpers shared by the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int CW      = 16;               // vertex coordinate width
    localparam int NFB     = 14;               // normal fraction bits
    localparam int NORM_W  = NFB + 2;          // normal component width
    localparam int EW      = CW + 1;           // edge vector width
    localparam int PW      = 2 * EW;           // edge product width
    localparam int NW      = 2 * CW + 3;       // cross product width
    localparam int AW      = 30;               // normalized magnitude width
    localparam int MW      = (NW > AW + 1) ? NW : AW + 1;
    localparam int SCNT    = MW - AW;          // candidate right shifts
    localparam int SHW     = $clog2(SCNT + 1);
    localparam int SQW     = 2 * AW;
    localparam int SW      = 2 * AW + 2;       // sum of squares width
    localparam int LW      = AW + 1;           // length (root) width
    localparam int QW      = NFB + 1;          // quotient width, holds one
    localparam int DW      = AW + NFB + 1;     // dividend width
    localparam int NORM_ONE = 1 << NFB;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic signed [CW-1:0] second_z;
        logic signed [CW-1:0] third_x;
        logic signed [CW-1:0] third_y;
        logic signed [CW-1:0] third_z;
    } t_in_item;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     degenerate;
    } t_out_item;

    // per-item data riding alongside the root and divide pipelines
    typedef struct packed {
        logic                   deg;
        logic [2:0]             neg;
        logic [2:0][AW-1:0]     a;
    } t_side;

    function automatic logic signed [EW-1:0] edge_diff(
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] a
    );
        return EW'(b) - EW'(a);
    endfunction

endpackage

/* design/tfn_isqrt.sv */
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tfn_isqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [tfn_pkg::SW-1:0] i_sq,
    input  tfn_pkg::t_side        i_side,
    output logic                  o_valid,
    output logic [tfn_pkg::LW-1:0] o_root,
    output tfn_pkg::t_side        o_side
);

    localparam int SW = tfn_pkg::SW;
    localparam int LW = tfn_pkg::LW;

    logic [SW-1:0]   r_rem  [1:LW];
    logic [LW-1:0]   r_root [1:LW];
    tfn_pkg::t_side  r_side [1:LW];
    logic            r_v    [1:LW];

    for (genvar k = 0; k < LW; k++) begin : g_stage
        localparam int B = LW - 1 - k;
        logic [SW-1:0]  rem_cur;
        logic [SW-1:0]  cand;
        logic [LW-1:0]  root_cur;
        tfn_pkg::t_side side_cur;
        logic           v_cur;

        if (k == 0) begin : g_first
            assign rem_cur  = i_sq;
            assign root_cur = '0;
            assign side_cur = i_side;
            assign v_cur    = i_valid;
        end else begin : g_next
            assign rem_cur  = r_rem[k];
            assign root_cur = r_root[k];
            assign side_cur = r_side[k];
            assign v_cur    = r_v[k];
        end

        // (root + 2^B)^2 - root^2
        assign cand = (SW'(root_cur) << (B + 1)) + (SW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_cur;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_cur >= cand) begin
                    r_rem[k+1]  <= rem_cur - cand;
                    r_root[k+1] <= root_cur | (LW'(1) << B);
                end else begin
                    r_rem[k+1]  <= rem_cur;
                    r_root[k+1] <= root_cur;
                end
                r_side[k+1] <= side_cur;
            end
        end
    end

    assign o_valid = r_v[LW];
    assign o_root  = r_root[LW];
    assign o_side  = r_side[LW];

endmodule

/* design/tfn_div.sv */
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined rounded divide of three magnitudes by a shared length.
// ----------------------------------------------------------------------------
module tfn_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [tfn_pkg::LW-1:0]            i_root,
    input  tfn_pkg::t_side                    i_side,
    output logic                              o_valid,
    output logic [2:0][tfn_pkg::QW-1:0]       o_q,
    output tfn_pkg::t_side                    o_side
);

    localparam int LW  = tfn_pkg::LW;
    localparam int QW  = tfn_pkg::QW;
    localparam int DW  = tfn_pkg::DW;
    localparam int NFB = tfn_pkg::NFB;

    logic [DW-1:0]   r_rem  [0:QW][0:2];
    logic [QW-1:0]   r_q    [1:QW][0:2];
    logic [LW-1:0]   r_l    [0:QW-1];
    tfn_pkg::t_side  r_side [0:QW];
    logic            r_v    [0:QW];

    // entry: dividend gets half the divisor added for rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (DW'(i_side.a[i]) << NFB) + DW'(i_root >> 1);
            end
            r_l[0]    <= i_root;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic [DW-1:0] cand;
        logic [QW-1:0] q_prev [0:2];

        assign cand = DW'(r_l[j]) << B;

        for (genvar i = 0; i < 3; i++) begin : g_lane
            if (j == 0) begin : g_first
                assign q_prev[i] = '0;
            end else begin : g_next
                assign q_prev[i] = r_q[j][i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[j][i] >= cand) begin
                        r_rem[j+1][i] <= r_rem[j][i] - cand;
                        r_q[j+1][i]   <= q_prev[i] | (QW'(1) << B);
                    end else begin
                        r_rem[j+1][i] <= r_rem[j][i];
                        r_q[j+1][i]   <= q_prev[i];
                    end
                end
                r_side[j+1] <= r_side[j];
            end
        end

        if (j + 1 < QW) begin : g_len
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_l[j+1] <= r_l[j];
                end
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_side  = r_side[QW];
    for (genvar i = 0; i < 3; i++) begin : g_out
        assign o_q[i] = r_q[QW][i];
    end

endmodule

/* design/triangle_face_normal.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: edges, cross product, length, divide.
// ----------------------------------------------------------------------------
// Pipeline: 9 front stages, 31 square-root stages, 16 divide stages and
//   an output register.
// Throughput: one item per cycle; the whole pipe stalls only while a
//   finished item waits on i_out_ready.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module triangle_face_normal (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tfn_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tfn_pkg::t_out_item  o_out_item
);

    localparam int EW    = tfn_pkg::EW;
    localparam int PW    = tfn_pkg::PW;
    localparam int NW    = tfn_pkg::NW;
    localparam int AW    = tfn_pkg::AW;
    localparam int MW    = tfn_pkg::MW;
    localparam int SCNT  = tfn_pkg::SCNT;
    localparam int SHW   = tfn_pkg::SHW;
    localparam int SQW   = tfn_pkg::SQW;
    localparam int SW    = tfn_pkg::SW;
    localparam int LW    = tfn_pkg::LW;
    localparam int QW    = tfn_pkg::QW;
    localparam int NORM_W = tfn_pkg::NORM_W;
    localparam int NPRE  = 9;

    logic                en;
    logic [NPRE:1]       r_v;
    logic                r_out_valid;
    tfn_pkg::t_out_item  r_out_item;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NPRE-1:1], i_in_valid};
        end
    end

    // stage 1: edge vectors
    logic signed [EW-1:0] r1_e1 [0:2];
    logic signed [EW-1:0] r1_e2 [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_e1[0] <= tfn_pkg::edge_diff(i_in_item.second_x, i_in_item.first_x);
            r1_e1[1] <= tfn_pkg::edge_diff(i_in_item.second_y, i_in_item.first_y);
            r1_e1[2] <= tfn_pkg::edge_diff(i_in_item.second_z, i_in_item.first_z);
            r1_e2[0] <= tfn_pkg::edge_diff(i_in_item.third_x, i_in_item.first_x);
            r1_e2[1] <= tfn_pkg::edge_diff(i_in_item.third_y, i_in_item.first_y);
            r1_e2[2] <= tfn_pkg::edge_diff(i_in_item.third_z, i_in_item.first_z);
        end
    end

    // stage 2: six partial products
    logic signed [PW-1:0] r2_p [0:5];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p[0] <= r1_e1[1] * r1_e2[2];
            r2_p[1] <= r1_e1[2] * r1_e2[1];
            r2_p[2] <= r1_e1[2] * r1_e2[0];
            r2_p[3] <= r1_e1[0] * r1_e2[2];
            r2_p[4] <= r1_e1[0] * r1_e2[1];
            r2_p[5] <= r1_e1[1] * r1_e2[0];
        end
    end

    // stage 3: cross product
    logic signed [NW-1:0] r3_n [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_n[0] <= NW'(r2_p[0]) - NW'(r2_p[1]);
            r3_n[1] <= NW'(r2_p[2]) - NW'(r2_p[3]);
            r3_n[2] <= NW'(r2_p[4]) - NW'(r2_p[5]);
        end
    end

    // stage 4: sign and magnitude
    logic [NW-1:0] r4_mag [0:2];
    logic [2:0]    r4_neg;
    logic          r4_deg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r4_mag[i] <= r3_n[i][NW-1] ? NW'(-r3_n[i]) : NW'(r3_n[i]);
                r4_neg[i] <= r3_n[i][NW-1];
            end
            r4_deg <= (r3_n[0] == '0) && (r3_n[1] == '0) && (r3_n[2] == '0);
        end
    end

    // stage 5: largest magnitude
    logic [NW-1:0] r5_mag [0:2];
    logic [NW-1:0] r5_max;
    logic [2:0]    r5_neg;
    logic          r5_deg;
    logic [NW-1:0] max01;

    assign max01 = (r4_mag[0] >= r4_mag[1]) ? r4_mag[0] : r4_mag[1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mag <= r4_mag;
            r5_max <= (max01 >= r4_mag[2]) ? max01 : r4_mag[2];
            r5_neg <= r4_neg;
            r5_deg <= r4_deg;
        end
    end

    // stage 6: right shift that brings the largest magnitude below 2^AW
    logic [NW-1:0]  r6_mag [0:2];
    logic [SHW-1:0] r6_sh;
    logic [2:0]     r6_neg;
    logic           r6_deg;
    logic [MW-1:0]  max_ext;
    logic [SHW-1:0] sh_cnt;

    always_comb begin
        max_ext = MW'(r5_max);
        sh_cnt  = '0;
        for (int k = 0; k < SCNT; k++) begin
            if ((max_ext >> (AW + k)) != '0) begin
                sh_cnt = sh_cnt + SHW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mag <= r5_mag;
            r6_sh  <= sh_cnt;
            r6_neg <= r5_neg;
            r6_deg <= r5_deg;
        end
    end

    // stage 7: apply shift
    logic [AW-1:0] r7_a [0:2];
    logic [2:0]    r7_neg;
    logic          r7_deg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_a[i] <= AW'(MW'(r6_mag[i]) >> r6_sh);
            end
            r7_neg <= r6_neg;
            r7_deg <= r6_deg;
        end
    end

    // stage 8: squares
    logic [SQW-1:0] r8_sq [0:2];
    logic [AW-1:0]  r8_a  [0:2];
    logic [2:0]     r8_neg;
    logic           r8_deg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_sq[i] <= r7_a[i] * r7_a[i];
            end
            r8_a   <= r7_a;
            r8_neg <= r7_neg;
            r8_deg <= r7_deg;
        end
    end

    // stage 9: sum of squares
    logic [SW-1:0]  r9_sum;
    tfn_pkg::t_side r9_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_sum       <= SW'(r8_sq[0]) + SW'(r8_sq[1]) + SW'(r8_sq[2]);
            r9_side.deg  <= r8_deg;
            r9_side.neg  <= r8_neg;
            for (int i = 0; i < 3; i++) begin
                r9_side.a[i] <= r8_a[i];
            end
        end
    end

    // length and divide
    logic               sq_valid;
    logic [LW-1:0]      sq_root;
    tfn_pkg::t_side     sq_side;
    logic               dv_valid;
    logic [2:0][QW-1:0] dv_q;
    tfn_pkg::t_side     dv_side;

    tfn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[NPRE]),
        .i_sq    (r9_sum),
        .i_side  (r9_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // output: clamp to one, restore sign, zero for a degenerate triangle
    logic [NORM_W-1:0] comp [0:2];

    always_comb begin
        logic [QW-1:0] sat;
        for (int i = 0; i < 3; i++) begin
            sat = (dv_q[i] > QW'(tfn_pkg::NORM_ONE)) ? QW'(tfn_pkg::NORM_ONE) : dv_q[i];
            if (dv_side.deg) begin
                comp[i] = '0;
            end else if (dv_side.neg[i]) begin
                comp[i] = NORM_W'(-NORM_W'(sat));
            end else begin
                comp[i] = NORM_W'(sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item.normal_x   <= comp[0];
            r_out_item.normal_y   <= comp[1];
            r_out_item.normal_z   <= comp[2];
            r_out_item.degenerate <= dv_side.deg;
        end
    end

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.degenerate |->
            o_out_item.normal_x == '0 && o_out_item.normal_y == '0 &&
            o_out_item.normal_z == '0)
        else $error("degenerate item with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_item.normal_x <= tfn_pkg::NORM_ONE &&
            o_out_item.normal_x >= -tfn_pkg::NORM_ONE &&
            o_out_item.normal_y <= tfn_pkg::NORM_ONE &&
            o_out_item.normal_y >= -tfn_pkg::NORM_ONE &&
            o_out_item.normal_z <= tfn_pkg::NORM_ONE &&
            o_out_item.normal_z >= -tfn_pkg::NORM_ONE)
        else $error("normal component outside unit range");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.degenerate |->
            o_out_item.normal_x != '0 || o_out_item.normal_y != '0 ||
            o_out_item.normal_z != '0)
        else $error("zero normal on a nondegenerate item");

endmodule

/* tb/tfn_checker.sv */
// ----------------------------------------------------------------------------
// tfn_checker
// Watches both channels of the face normal block, predicts each normal from
// the accepted triangle and compares it with each accepted result item.
// ----------------------------------------------------------------------------
module tfn_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tfn_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tfn_pkg::t_out_item  i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_normals_seen,
    output int                  o_degenerate_seen
);

    tfn_pkg::t_out_item expected_normals[$];

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic tfn_pkg::t_out_item face_normal(input tfn_pkg::t_in_item t);
        longint e1[3];
        longint e2[3];
        longint n[3];
        longint unsigned mag[3];
        longint unsigned peak;
        longint unsigned sumsq;
        longint unsigned len;
        longint unsigned q;
        logic [tfn_pkg::NORM_W-1:0] comp[3];
        int sh;
        tfn_pkg::t_out_item r;
        e1[0] = longint'(t.second_x) - longint'(t.first_x);
        e1[1] = longint'(t.second_y) - longint'(t.first_y);
        e1[2] = longint'(t.second_z) - longint'(t.first_z);
        e2[0] = longint'(t.third_x) - longint'(t.first_x);
        e2[1] = longint'(t.third_y) - longint'(t.first_y);
        e2[2] = longint'(t.third_z) - longint'(t.first_z);
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        peak = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
            if (mag[i] > peak) peak = mag[i];
        end
        sh = 0;
        while ((peak >> sh) >= (64'd1 << 30)) sh++;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] >>= sh;
            sumsq += mag[i] * mag[i];
        end
        len = int_sqrt(sumsq);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << tfn_pkg::NFB) + (len >> 1)) / len;
            if (q > tfn_pkg::NORM_ONE) q = tfn_pkg::NORM_ONE;
            if (n[i] < 0) q = -q;
            comp[i] = q[tfn_pkg::NORM_W-1:0];
        end
        r.normal_x = comp[0];
        r.normal_y = comp[1];
        r.normal_z = comp[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        tfn_pkg::t_out_item want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_normals_seen <= 0;
            o_degenerate_seen <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_normals = {expected_normals, face_normal(i_in_item)};
            if (i_out_valid && i_out_ready) begin
                o_normals_seen <= o_normals_seen + 1;
                if (i_out_item.degenerate) o_degenerate_seen <= o_degenerate_seen + 1;
                if (expected_normals.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected normal item %p", i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_normals.pop_front();
                    if (want !== i_out_item) begin
                        if (o_fail_count < 10)
                            $display("ERROR: normal mismatch exp %p got %p",
                                     want, i_out_item);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_normals.size();
    end
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random triangles into the face normal block with
// random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW = tfn_pkg::CW;
    localparam int NUM_RANDOM = 1830;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    tfn_pkg::t_in_item  in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    tfn_pkg::t_out_item out_item;
    int         fail_count;
    int         pending;
    int         normals_seen;
    int         degenerate_seen;
    int         idle_cycles = 0;
    bit         hold_off = 1'b0;
    tfn_pkg::t_in_item  directed[$];

    always #6 i_clk = ~i_clk;

    triangle_face_normal dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    tfn_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_item       (out_item),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_normals_seen   (normals_seen),
        .o_degenerate_seen(degenerate_seen)
    );

    function automatic tfn_pkg::t_in_item tri9(input int v[9]);
        tfn_pkg::t_in_item t;
        t.first_x = CW'(v[0]); t.first_y = CW'(v[1]); t.first_z = CW'(v[2]);
        t.second_x = CW'(v[3]); t.second_y = CW'(v[4]); t.second_z = CW'(v[5]);
        t.third_x = CW'(v[6]); t.third_y = CW'(v[7]); t.third_z = CW'(v[8]);
        return t;
    endfunction

    task automatic add_directed(input int v[9]);
        directed = {directed, tri9(v)};
    endtask

    // mostly small triangles near a random anchor, some full range, some flat
    function automatic tfn_pkg::t_in_item random_triangle();
        tfn_pkg::t_in_item t;
        int kind;
        int span;
        logic signed [CW-1:0] c[9];
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            t = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        end else begin
            span = 1 << $urandom_range(0, 15);
            for (int i = 0; i < 3; i++) c[i] = CW'($urandom);
            for (int i = 3; i < 9; i++)
                c[i] = CW'(c[i % 3] + $signed($urandom_range(0, 2 * span)) - span);
            if (kind == 9) begin
                // collinear: third vertex mirrors second about the first
                for (int i = 0; i < 3; i++) c[6 + i] = CW'(2 * c[i] - c[3 + i]);
            end
            t = tri9('{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]});
        end
        return t;
    endfunction

    task automatic send_triangle(input tfn_pkg::t_in_item t);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= t;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // receiver stalls; one long hold-off lets the pipe fill
    initial begin
        int stall;
        int accepted;
        accepted = 0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (accepted == 300) stall = 400;
            if (stall != 0) begin
                out_ready <= 1'b0;
                hold_off = (accepted == 300);
                repeat (stall) @(posedge i_clk);
                hold_off = 1'b0;
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            accepted++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int wait_count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        add_directed('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_directed('{0, 0, 0, 256, 0, 0, 0, 256, 0});
        add_directed('{0, 0, 0, 0, 256, 0, 256, 0, 0});
        add_directed('{0, 0, 0, 0, 0, 1, 1, 0, 0});
        add_directed('{0, 0, 0, 0, 1, 0, 0, 0, 1});
        add_directed('{5, 5, 5, 6, 5, 5, 5, 6, 5});
        add_directed('{-32768, -32768, -32768, 32767, -32768, -32768,
                       -32768, 32767, -32768});
        add_directed('{32767, 32767, 32767, -32768, 32767, 32767,
                       32767, -32768, 32767});
        add_directed('{-32768, -32768, -32768, 32767, 32767, -32768,
                       -32768, 32767, 32767});
        add_directed('{-32768, 32767, -32768, 32767, -32768, 32767,
                       32767, 32767, -32768});
        add_directed('{0, 0, 0, 100, 200, 300, 200, 400, 600});
        add_directed('{-1, -1, -1, -1, -1, -1, 7, 8, 9});
        add_directed('{0, 0, 0, 1, 1, 1, 1, 2, 3});
        add_directed('{0, 0, 0, 3, 0, 0, 0, 5, 7});
        add_directed('{0, 0, 0, 1, 1, 0, 1, -1, 1});
        add_directed('{-32768, -32768, -32768, -32768, -32768, -32768,
                       32767, 32767, 32767});
        add_directed('{32767, 0, -32768, 0, 32767, 0, -32768, -32768, 32767});
        add_directed('{-21846, -21846, -21846, 21845, 21845, 21845,
                       -21845, 21845, -1});
        foreach (directed[i]) send_triangle(directed[i]);
        for (int i = 0; i < NUM_RANDOM; i++) send_triangle(random_triangle());
        in_valid <= 1'b0;
        wait_count = 0;
        while (pending != 0 && wait_count < 20000) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d triangles, %0d normals checked, %0d degenerate.",
                 directed.size() + NUM_RANDOM, normals_seen, degenerate_seen);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
